[rtl/mep_pkg.sv]
// shared constants, types and helpers for the event-driven pwm block
package mep_pkg;

    localparam int NUM_SLOTS = 8;
    localparam int SLOT_IW   = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int OUT_BITS  = 8;
    localparam int VIS_SLOTS = (NUM_SLOTS < OUT_BITS) ? NUM_SLOTS : OUT_BITS;

    localparam logic [7:0] NO_COMPARE    = 8'hFF;
    localparam logic [7:0] MAX_WIDTH_RST = 8'hFF;
    localparam logic [7:0] SLOT_LIMIT    = 8'(NUM_SLOTS);

    localparam logic [2:0] CMD_TOP    = 3'd0;
    localparam logic [2:0] CMD_MATCH  = 3'd1;
    localparam logic [2:0] CMD_ADD    = 3'd2;
    localparam logic [2:0] CMD_REMOVE = 3'd3;
    localparam logic [2:0] CMD_SET    = 3'd4;

    // controller to datapath
    typedef struct packed {
        logic               load_in;
        logic               exec;
        logic               scan_top;
        logic               scan_match;
        logic               scan_first;
        logic               scan_last;
        logic [SLOT_IW-1:0] scan_idx;
        logic               load_out;
    } mep_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_scan;
        logic is_top;
    } mep_stat_t;

    // low slots as an output byte, upper bits zero when there are fewer slots
    function automatic logic [OUT_BITS-1:0] to_byte(input logic [NUM_SLOTS-1:0] v);
        logic [OUT_BITS-1:0] b;
        b = '0;
        for (int i = 0; i < VIS_SLOTS; i++)
        begin
            b[i] = v[i];
        end
        return b;
    endfunction

endpackage

[rtl/mep_ctrl.sv]
// sequencer for request decode, slot scan and result hand-off
module mep_ctrl
    import mep_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    input  mep_stat_t stat,
    output mep_cmd_t  cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_DECODE = 2'd1;
    localparam logic [1:0] ST_SCAN   = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    localparam logic [SLOT_IW-1:0] LAST_IDX = SLOT_IW'(NUM_SLOTS - 1);

    logic [1:0]         state_reg, state_next;
    logic [SLOT_IW-1:0] idx_reg, idx_next;
    logic               out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        cmd            = '0;
        cmd.scan_idx   = idx_reg;
        in_ready       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                cmd.exec = 1'b1;
                idx_next = '0;
                if (stat.is_scan)
                    state_next = ST_SCAN;
                else
                    state_next = ST_FINISH;
            end
            ST_SCAN:
            begin
                cmd.scan_top   = stat.is_top;
                cmd.scan_match = !stat.is_top;
                cmd.scan_first = (idx_reg == '0);
                cmd.scan_last  = (idx_reg == LAST_IDX);
                if (idx_reg == LAST_IDX)
                    state_next = ST_FINISH;
                else
                    idx_next = idx_reg + 1'b1;
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef SYNTH
    a_accept_to_decode: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg == ST_DECODE)
        else $error("accepted request did not move to decode");

    a_result_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || out_ready))
        else $error("result overwritten before it was taken");

    a_scan_steps: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN && !cmd.scan_last |=> state_reg == ST_SCAN
            && idx_reg == $past(idx_reg) + 1'b1)
        else $error("slot scan skipped or stalled");

    a_scan_ends_in_finish: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_last |=> state_reg == ST_FINISH)
        else $error("scan did not end in finish");
`endif

endmodule

[rtl/mep_datapath.sv]
// slot width stores, level and enable registers, compare search and result register
module mep_datapath
    import mep_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  mep_cmd_t   cmd,
    output mep_stat_t  stat,
    input  logic [2:0] in_cmd,
    input  logic [7:0] in_slot,
    input  logic [7:0] in_width,
    input  logic       cfg_we,
    input  logic [7:0] cfg_data,
    output logic [7:0] levels,
    output logic [7:0] next_compare,
    output logic [7:0] enabled_mask,
    output logic       status
);

    logic [2:0] cmd_reg;
    logic [7:0] slot_reg;
    logic [7:0] width_reg;
    logic [7:0] max_width_reg;

    logic [7:0]           shadow_reg [NUM_SLOTS];
    logic [7:0]           shadow_next [NUM_SLOTS];
    logic [7:0]           active_reg [NUM_SLOTS];
    logic [7:0]           active_next [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] enabled_reg, enabled_next;
    logic [NUM_SLOTS-1:0] levels_reg, levels_next;
    logic [7:0]           compare_reg, compare_next;
    logic [7:0]           least_reg, least_next;
    logic                 rej_reg, rej_next;

    logic [7:0] levels_out_reg, compare_out_reg, enabled_out_reg;
    logic       status_out_reg;

    logic [SLOT_IW-1:0] sidx;
    logic               slot_ok, width_ok, en_sel, rejected;
    logic [7:0]         sh_rd, ac_rd, least_cur;

    assign stat.is_scan = (cmd_reg == CMD_TOP) || (cmd_reg == CMD_MATCH);
    assign stat.is_top  = (cmd_reg == CMD_TOP);

    assign sidx     = slot_reg[SLOT_IW-1:0];
    assign slot_ok  = (slot_reg < SLOT_LIMIT);
    assign width_ok = (width_reg <= max_width_reg);
    assign en_sel   = enabled_reg[sidx];
    assign sh_rd    = shadow_reg[cmd.scan_idx];
    assign ac_rd    = active_reg[cmd.scan_idx];
    assign least_cur = cmd.scan_first ? NO_COMPARE : least_reg;

    always_comb
    begin
        case (cmd_reg)
            CMD_TOP:    rejected = 1'b0;
            CMD_MATCH:  rejected = 1'b0;
            CMD_ADD:    rejected = !slot_ok || !width_ok || en_sel;
            CMD_REMOVE: rejected = !slot_ok;
            CMD_SET:    rejected = !slot_ok || !width_ok || !en_sel;
            default:    rejected = 1'b1;
        endcase
    end

    always_comb
    begin
        shadow_next  = shadow_reg;
        active_next  = active_reg;
        enabled_next = enabled_reg;
        levels_next  = levels_reg;
        compare_next = compare_reg;
        least_next   = least_reg;
        rej_next     = rej_reg;

        if (cmd.exec)
        begin
            rej_next = rejected;
            if (!rejected)
            begin
                case (cmd_reg)
                    CMD_ADD:
                    begin
                        enabled_next[sidx] = 1'b1;
                        shadow_next[sidx]  = width_reg;
                    end
                    CMD_REMOVE:
                    begin
                        enabled_next[sidx] = 1'b0;
                        shadow_next[sidx]  = 8'd0;
                        levels_next[sidx]  = 1'b0;
                    end
                    CMD_SET:
                    begin
                        shadow_next[sidx] = width_reg;
                    end
                    default:
                    begin
                        rej_next = rejected;
                    end
                endcase
            end
        end

        // one slot per cycle, running minimum kept in least_reg
        if (cmd.scan_top)
        begin
            active_next[cmd.scan_idx] = sh_rd;
            least_next = least_cur;
            if (sh_rd != 8'd0)
            begin
                levels_next[cmd.scan_idx] = 1'b1;
                if (sh_rd < least_cur)
                    least_next = sh_rd;
            end
            if (cmd.scan_last)
                compare_next = least_next;
        end
        else if (cmd.scan_match)
        begin
            least_next = least_cur;
            if (ac_rd == compare_reg)
                levels_next[cmd.scan_idx] = 1'b0;
            if (ac_rd > compare_reg && ac_rd < least_cur)
                least_next = ac_rd;
            if (cmd.scan_last)
                compare_next = least_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                shadow_reg[i] <= 8'd0;
                active_reg[i] <= 8'd0;
            end
            enabled_reg   <= '0;
            levels_reg    <= '0;
            compare_reg   <= NO_COMPARE;
            max_width_reg <= MAX_WIDTH_RST;
        end
        else
        begin
            shadow_reg  <= shadow_next;
            active_reg  <= active_next;
            enabled_reg <= enabled_next;
            levels_reg  <= levels_next;
            compare_reg <= compare_next;
            if (cfg_we)
                max_width_reg <= cfg_data;
        end
    end

    // request and result payload and the scan minimum, no reset needed
    always_ff @(posedge clk)
    begin
        least_reg <= least_next;
        rej_reg   <= rej_next;
        if (cmd.load_in)
        begin
            cmd_reg   <= in_cmd;
            slot_reg  <= in_slot;
            width_reg <= in_width;
        end
        if (cmd.load_out)
        begin
            levels_out_reg  <= to_byte(levels_reg);
            compare_out_reg <= compare_reg;
            enabled_out_reg <= to_byte(enabled_reg);
            status_out_reg  <= rej_reg;
        end
    end

    assign levels       = levels_out_reg;
    assign next_compare = compare_out_reg;
    assign enabled_mask = enabled_out_reg;
    assign status       = status_out_reg;

endmodule

[rtl/multichannel_event_pwm.sv]
// top level of the multi-slot event-driven pwm with shadowed widths
//
//  channel  | handshake             | payload
//  ---------+-----------------------+---------------------------------------------
//  request  | in_valid / in_ready   | cmd, slot, duty
//  result   | out_valid / out_ready | levels, next_compare, enabled_mask, status
//  config   | cfg_we                | cfg_data (max_width)
//
// add, remove, set and unknown requests go from decode straight to finish before the next accept
// period top and compare match pass through a scan state between decode and finish: the compare search
// walks the width store one slot per cycle
// the result register frees the controller as soon as the finish step loads it;
// a stalled result holds the block in finish until it is taken
// reset clears all widths, enables and levels and sets the compare value to 255
module multichannel_event_pwm
    import mep_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [2:0] cmd,
    input  logic [7:0] slot,
    input  logic [7:0] duty,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] levels,
    output logic [7:0] next_compare,
    output logic [7:0] enabled_mask,
    output logic       status,
    input  logic       cfg_we,
    input  logic [7:0] cfg_data
);

    mep_cmd_t  dp_cmd;
    mep_stat_t dp_stat;

    mep_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (dp_stat),
        .cmd       (dp_cmd)
    );

    mep_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (dp_cmd),
        .stat         (dp_stat),
        .in_cmd       (cmd),
        .in_slot      (slot),
        .in_width     (duty),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .levels       (levels),
        .next_compare (next_compare),
        .enabled_mask (enabled_mask),
        .status       (status)
    );

endmodule

[test/multichannel_event_pwm_test.sv]
// self-checking testbench for the multi-slot event-driven pwm block
module multichannel_event_pwm_test;
    import mep_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] CMD_UNKNOWN_LO = CMD_SET + 3'd1;
    localparam logic [2:0] CMD_UNKNOWN_HI = '1;
    localparam int SETTLE_CYCLES = NUM_SLOTS + 8;

    typedef struct packed {
        logic [7:0] levels;
        logic [7:0] next_compare;
        logic [7:0] enabled_mask;
        logic       status;
    } pwm_result_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [2:0] cmd = CMD_TOP;
    logic [7:0] slot = '0;
    logic [7:0] duty = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] levels;
    logic [7:0] next_compare;
    logic [7:0] enabled_mask;
    logic       status;
    logic       cfg_we = 1'b0;
    logic [7:0] cfg_data = '0;

    // shadow copy of the block state
    logic [7:0]           shadow_w [NUM_SLOTS];
    logic [7:0]           active_w [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] slot_on;
    logic [NUM_SLOTS-1:0] level_bits;
    logic [7:0]           compare_now;
    logic [7:0]           width_limit;

    pwm_result_t pending_results[$];
    int          error_count = 0;
    int          sender_idle_pct = 0;
    int          receiver_stall_pct = 0;
    int          hold_request = 0;
    int          hold_left = 0;

    multichannel_event_pwm dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .cmd          (cmd),
        .slot         (slot),
        .duty         (duty),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .levels       (levels),
        .next_compare (next_compare),
        .enabled_mask (enabled_mask),
        .status       (status),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic logic [7:0] low_byte(input logic [NUM_SLOTS-1:0] v);
        logic [7:0] b;
        b = '0;
        for (int i = 0; i < NUM_SLOTS && i < 8; i++)
        begin
            b[i] = v[i];
        end
        return b;
    endfunction

    function automatic void clear_pwm_state();
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            shadow_w[i] = '0;
            active_w[i] = '0;
        end
        slot_on = '0;
        level_bits = '0;
        compare_now = NO_COMPARE;
        width_limit = MAX_WIDTH_RST;
    endfunction

    // applies one request to the shadow state and returns the result it gives
    function automatic pwm_result_t apply_request(input logic [2:0] op,
                                                  input logic [7:0] idx,
                                                  input logic [7:0] w);
        pwm_result_t r;
        logic [7:0]  least;
        logic        bad_slot;
        int          s;
        least = NO_COMPARE;
        bad_slot = (idx >= NUM_SLOTS);
        s = bad_slot ? 0 : int'(idx);
        r.status = 1'b0;
        case (op)
            CMD_TOP:
            begin
                for (int i = 0; i < NUM_SLOTS; i++)
                begin
                    active_w[i] = shadow_w[i];
                    if (active_w[i] != 0)
                    begin
                        level_bits[i] = 1'b1;
                        if (active_w[i] < least)
                            least = active_w[i];
                    end
                end
                compare_now = least;
            end
            CMD_MATCH:
            begin
                for (int i = 0; i < NUM_SLOTS; i++)
                begin
                    if (active_w[i] == compare_now)
                        level_bits[i] = 1'b0;
                    if (active_w[i] > compare_now && active_w[i] < least)
                        least = active_w[i];
                end
                compare_now = least;
            end
            CMD_ADD:
            begin
                if (bad_slot || w > width_limit || slot_on[s])
                    r.status = 1'b1;
                else
                begin
                    slot_on[s] = 1'b1;
                    shadow_w[s] = w;
                end
            end
            CMD_REMOVE:
            begin
                if (bad_slot)
                    r.status = 1'b1;
                else
                begin
                    shadow_w[s] = '0;
                    slot_on[s] = 1'b0;
                    level_bits[s] = 1'b0;
                end
            end
            CMD_SET:
            begin
                if (bad_slot || w > width_limit || !slot_on[s])
                    r.status = 1'b1;
                else
                    shadow_w[s] = w;
            end
            default:
                r.status = 1'b1;
        endcase
        r.levels = low_byte(level_bits);
        r.next_compare = compare_now;
        r.enabled_mask = low_byte(slot_on);
        return r;
    endfunction

    function automatic int draw_gap();
        int gap;
        gap = 0;
        while (gap < 60 && $urandom_range(99) < sender_idle_pct)
            gap++;
        return gap;
    endfunction

    // offers one request, waits for it to be taken and records its result
    task automatic send_request(input logic [2:0] op, input logic [7:0] idx,
                                input logic [7:0] w);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd <= op;
        slot <= idx;
        duty <= w;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_results.push_back(apply_request(op, idx, w));
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_max_width(input logic [7:0] value);
        wait_idle();
        cfg_we <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        width_limit = value;
    endtask

    function automatic logic [7:0] pick_width();
        if ($urandom_range(99) < 10)
            return 8'($urandom);
        return 8'($urandom_range(int'(width_limit), 0));
    endfunction

    // mostly legal edits, driven from the current enable state
    task automatic send_edit();
        int s;
        s = $urandom_range(NUM_SLOTS - 1);
        if (!slot_on[s])
            send_request(CMD_ADD, 8'(s), pick_width());
        else if ($urandom_range(99) < 70)
            send_request(CMD_SET, 8'(s), pick_width());
        else
            send_request(CMD_REMOVE, 8'(s), 8'($urandom));
    endtask

    // pwm frames: edits, a period top and a run of compare matches, plus noise
    task automatic run_frames(input int item_count);
        int sent;
        int edits;
        int match_count;
        sent = 0;
        while (sent < item_count)
        begin
            if ($urandom_range(99) < 20)
            begin
                send_request(3'($urandom_range(7)), 8'($urandom), 8'($urandom));
                sent++;
            end
            else
            begin
                edits = $urandom_range(3);
                repeat (edits) send_edit();
                send_request(CMD_TOP, 8'($urandom), 8'($urandom));
                match_count = $urandom_range(NUM_SLOTS + 1, 1);
                repeat (match_count) send_request(CMD_MATCH, 8'($urandom), 8'($urandom));
                sent += edits + 1 + match_count;
            end
        end
    endtask

    task automatic test_timer_events_empty();
        send_request(CMD_TOP, 8'hFF, 8'hFF);
        send_request(CMD_MATCH, 8'h00, 8'h00);
    endtask

    task automatic test_command_checks();
        send_request(CMD_ADD, 8'd0, 8'd255);
        send_request(CMD_ADD, 8'(NUM_SLOTS - 1), 8'd1);
        send_request(CMD_ADD, 8'(NUM_SLOTS), 8'd5);
        send_request(CMD_ADD, 8'd255, 8'd5);
        send_request(CMD_ADD, 8'd0, 8'd3);
        send_request(CMD_SET, 8'd3, 8'd4);
        send_request(CMD_SET, 8'(NUM_SLOTS - 1), 8'd128);
        send_request(CMD_REMOVE, 8'd5, 8'd0);
        for (int c = CMD_UNKNOWN_LO; c <= CMD_UNKNOWN_HI; c++)
        begin
            send_request(3'(c), 8'd1, 8'd1);
        end
        send_request(CMD_TOP, 8'd0, 8'd0);
        send_request(CMD_MATCH, 8'd0, 8'd0);
        send_request(CMD_MATCH, 8'd0, 8'd0);
        // remove pulls the slot low right away
        send_request(CMD_REMOVE, 8'd0, 8'd0);
        send_request(CMD_SET, 8'd255, 8'd1);
        send_request(CMD_REMOVE, 8'd200, 8'd0);
    endtask

    task automatic test_width_limit();
        set_max_width(8'd0);
        send_request(CMD_ADD, 8'd2, 8'd1);
        send_request(CMD_ADD, 8'd2, 8'd0);
        send_request(CMD_SET, 8'(NUM_SLOTS - 1), 8'd1);
        set_max_width(8'd128);
        send_request(CMD_SET, 8'(NUM_SLOTS - 1), 8'd129);
        send_request(CMD_SET, 8'(NUM_SLOTS - 1), 8'd128);
        send_request(CMD_TOP, 8'd0, 8'd0);
        send_request(CMD_MATCH, 8'd0, 8'd0);
    endtask

    task automatic test_random_phases();
        set_max_width(8'd255);
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        run_frames(240);
        set_max_width(8'd200);
        sender_idle_pct = 85;
        run_frames(220);
        set_max_width(8'd1);
        sender_idle_pct = 0;
        receiver_stall_pct = 85;
        run_frames(200);
        set_max_width(8'($urandom));
        sender_idle_pct = 9;
        receiver_stall_pct = 9;
        run_frames(240);
        set_max_width(8'd0);
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        run_frames(100);
        set_max_width(8'd255);
        sender_idle_pct = 30;
        receiver_stall_pct = 50;
        run_frames(300);
    endtask

    // long receiver hold-off while requests keep coming, then a full drain
    task automatic test_backpressure();
        wait_idle();
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        hold_request = 300;
        run_frames(40);
        wait_idle();
    endtask

    always @(posedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    always @(posedge clk)
    begin
        pwm_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with no request outstanding");
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (levels !== want.levels)
                begin
                    $error("levels: expected %h, got %h", want.levels, levels);
                    error_count++;
                end
                if (next_compare !== want.next_compare)
                begin
                    $error("next_compare: expected %h, got %h",
                           want.next_compare, next_compare);
                    error_count++;
                end
                if (enabled_mask !== want.enabled_mask)
                begin
                    $error("enabled_mask: expected %h, got %h",
                           want.enabled_mask, enabled_mask);
                    error_count++;
                end
                if (status !== want.status)
                begin
                    $error("status: expected %b, got %b", want.status, status);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        clear_pwm_state();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_timer_events_empty();
        test_command_checks();
        test_width_limit();
        test_random_phases();
        test_backpressure();
        wait_idle();
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
